FILE: sv/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants for the sorted multiset table
// Opcodes, status codes, controller states and the control bundle that the
// controller broadcasts along the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

   // Field widths of the request and response words
   localparam int OPCODE_W   = 2;
   localparam int IO_KEY_W   = 32;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 16;
   localparam int ENTRIES_W  = 5;

   // tdata widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 56;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_COUNT  = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_UPDATE = 1'b1
   } state_type;

   // Broadcast to every cell
   typedef struct packed {
      logic   load;    // register compare flags against op_key
      logic   update;  // apply the decided change
      op_type op;
      logic   ins;     // insert a new key, cells above shift up
      logic   rem;     // drop the matching entry, cells above shift down
      logic   inc;     // bump the matching count
      logic   dec;     // lower the matching count
   } ctl_type;

endpackage

`default_nettype wire

FILE: sv/smt_cell.sv
// ----------------------------------------------------------------------------
// smt_cell: one entry of the sorted multiset table
// Holds a key and its count, compares against the broadcast key, and takes
// its neighbor's entry when the row shifts on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int COUNT_WIDTH = 16,
   parameter int USED_WIDTH  = 5,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smt_pkg::ctl_type              ctl,
   input  logic signed [KEY_WIDTH-1:0]   op_key,
   input  logic [USED_WIDTH-1:0]         used,
   input  logic [smt_pkg::POSITION_W-1:0] pos,
   input  logic signed [KEY_WIDTH-1:0]   left_key,
   input  logic [COUNT_WIDTH-1:0]        left_count,
   input  logic                          left_gt,
   input  logic signed [KEY_WIDTH-1:0]   right_key,
   input  logic [COUNT_WIDTH-1:0]        right_count,
   output logic signed [KEY_WIDTH-1:0]   key,
   output logic [COUNT_WIDTH-1:0]        count,
   output logic                          gt,
   output logic                          match,
   output logic                          last,
   output logic                          sel,
   output logic signed [KEY_WIDTH-1:0]   rpt_key,
   output logic [COUNT_WIDTH-1:0]        rpt_count
);
   import smt_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic gt_ff, ge_ff, match_ff, last_ff, sel_ff;
   logic valid;

   assign valid = used > USED_WIDTH'(INDEX);

   // Compare flags; an empty cell counts as greater than any key
   always_ff @(posedge clock) begin
      if (reset) begin
         gt_ff    <= 1'b0;
         ge_ff    <= 1'b0;
         match_ff <= 1'b0;
         last_ff  <= 1'b0;
         sel_ff   <= 1'b0;
      end else if (ctl.load) begin
         gt_ff    <= !valid || (key_ff > op_key);
         ge_ff    <= valid && (key_ff >= op_key);
         match_ff <= valid && (key_ff == op_key);
         last_ff  <= valid && (key_ff == op_key) && (count_ff == COUNT_ONE);
         sel_ff   <= valid && (32'(pos) == 32'(INDEX));
      end
   end

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      if (ctl.update) begin
         priority if (ctl.ins) begin
            if (left_gt) begin
               key_in   = left_key;
               count_in = left_count;
            end else if (gt_ff) begin
               key_in   = op_key;
               count_in = COUNT_ONE;
            end
         end else if (ctl.rem) begin
            if (ge_ff) begin
               key_in   = right_key;
               count_in = right_count;
            end
         end else if (ctl.inc) begin
            if (match_ff && count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_ONE;
            end
         end else if (ctl.dec) begin
            if (match_ff) begin
               count_in = count_ff - COUNT_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   // Count after the operation, zero unless this cell is the one addressed
   always_comb begin
      rpt_count = '0;
      unique case (ctl.op)
         OP_ADD: begin
            if (match_ff) begin
               rpt_count = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;
            end
         end
         OP_REMOVE: begin
            if (match_ff) begin
               rpt_count = count_ff - COUNT_ONE;
            end
         end
         OP_COUNT: begin
            if (match_ff) begin
               rpt_count = count_ff;
            end
         end
         OP_GET: begin
            if (sel_ff) begin
               rpt_count = count_ff;
            end
         end
         default: rpt_count = '0;
      endcase
   end

   assign rpt_key = (ctl.op == OP_GET && sel_ff) ? key_ff : '0;
   assign key     = key_ff;
   assign count   = count_ff;
   assign gt      = gt_ff;
   assign match   = match_ff;
   assign last    = last_ff;
   assign sel     = sel_ff;

endmodule

`default_nettype wire

FILE: sv/sorted_multiset_table_unit.sv
// The compare flags are latched at the edge that accepts a request word;
// the shift/update cycle follows, and its response word is registered onto rsp.
// A new request is taken only in idle, once the compare-then-shift pass over
// the row of cells is through; a stalled response holds off the update cycle.
// Reset: synchronous, clears the entry count and handshake state; keys and
// counts need no clearing pass since only entries below the count are read.
// ----------------------------------------------------------------------------
// sorted_multiset_table_unit: sorted multiset with occurrence counts
// A row of cells keeps distinct signed keys in ascending order with counts;
// add, remove, count and get-by-position operations, one response per word.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_multiset_table_unit #(
   parameter int CAPACITY    = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] opcode, [33:2] key, [37:34] position, [39:38] zero
   input  logic [smt_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [17:2] occurrences, [49:18] nth_key, [54:50] entries, [55] zero
   output logic [smt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import smt_pkg::*;

   localparam int USED_WIDTH = $clog2(CAPACITY + 1);
   localparam logic [USED_WIDTH-1:0] USED_FULL = USED_WIDTH'(CAPACITY);
   localparam logic [USED_WIDTH-1:0] USED_ONE  = USED_WIDTH'(1);

   state_type state_ff, state_in;
   logic [USED_WIDTH-1:0] used_ff, used_in;
   op_type op_ff;
   logic signed [KEY_WIDTH-1:0] key_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept, do_update, full;
   logic any_match, any_last, any_sel;
   logic signed [IO_KEY_W-1:0] req_key;
   logic signed [63:0] req_key_wide;
   logic signed [KEY_WIDTH-1:0] in_key, op_key;
   ctl_type ctl;

   logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic [COUNT_WIDTH-1:0]      cell_count [CAPACITY];
   logic signed [KEY_WIDTH-1:0] cell_rpt_key [CAPACITY];
   logic [COUNT_WIDTH-1:0]      cell_rpt_count [CAPACITY];
   logic [CAPACITY-1:0] gt_vec, match_vec, last_vec, sel_vec;

   logic [COUNT_WIDTH-1:0]      occ_or, occ_full;
   logic signed [KEY_WIDTH-1:0] key_or;
   logic [63:0] occ_wide, used_wide;
   logic signed [63:0] nth_wide;
   status_type status;
   logic [OCC_W-1:0] occ;

   assign accept       = req_tvalid && req_tready;
   assign req_key      = req_tdata[33:2];
   assign req_key_wide = 64'(req_key);
   assign in_key       = req_key_wide[KEY_WIDTH-1:0];
   assign op_key       = (state_ff == S_IDLE) ? in_key : key_ff;
   assign full         = used_ff == USED_FULL;

   assign any_match = |match_vec;
   assign any_last  = |last_vec;
   assign any_sel   = |sel_vec;

   // ------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_tdata[1:0]);
         key_ff <= in_key;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      do_update    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               do_update    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      ctl.load   = accept;
      ctl.update = do_update;
      ctl.op     = op_ff;
      ctl.ins    = (op_ff == OP_ADD) && !any_match && !full;
      ctl.rem    = (op_ff == OP_REMOVE) && any_last;
      ctl.inc    = (op_ff == OP_ADD) && any_match;
      ctl.dec    = (op_ff == OP_REMOVE) && any_match && !any_last;
   end

   // ------------------------------------------------------------------
   // Cell row
   // ------------------------------------------------------------------
   for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
      logic signed [KEY_WIDTH-1:0] left_key, right_key;
      logic [COUNT_WIDTH-1:0]      left_count, right_count;
      logic                        left_gt;

      if (c == 0) begin : g_first
         assign left_key   = '0;
         assign left_count = '0;
         assign left_gt    = 1'b0;
      end else begin : g_inner
         assign left_key   = cell_key[c-1];
         assign left_count = cell_count[c-1];
         assign left_gt    = gt_vec[c-1];
      end

      // the top cell shifts in itself; it is empty after a remove anyway
      if (c == CAPACITY - 1) begin : g_top
         assign right_key   = cell_key[c];
         assign right_count = cell_count[c];
      end else begin : g_below
         assign right_key   = cell_key[c+1];
         assign right_count = cell_count[c+1];
      end

      smt_cell #(
         .KEY_WIDTH   (KEY_WIDTH),
         .COUNT_WIDTH (COUNT_WIDTH),
         .USED_WIDTH  (USED_WIDTH),
         .INDEX       (c)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .op_key      (op_key),
         .used        (used_ff),
         .pos         (req_tdata[37:34]),
         .left_key    (left_key),
         .left_count  (left_count),
         .left_gt     (left_gt),
         .right_key   (right_key),
         .right_count (right_count),
         .key         (cell_key[c]),
         .count       (cell_count[c]),
         .gt          (gt_vec[c]),
         .match       (match_vec[c]),
         .last        (last_vec[c]),
         .sel         (sel_vec[c]),
         .rpt_key     (cell_rpt_key[c]),
         .rpt_count   (cell_rpt_count[c])
      );
   end

   // ------------------------------------------------------------------
   // Response word; at most one cell reports a nonzero value
   // ------------------------------------------------------------------
   always_comb begin
      occ_or = '0;
      key_or = '0;
      for (int c = 0; c < CAPACITY; c++) begin
         occ_or = occ_or | cell_rpt_count[c];
         key_or = key_or | cell_rpt_key[c];
      end
   end

   always_comb begin
      if (ctl.ins) begin
         used_in = used_ff + USED_ONE;
      end else if (ctl.rem) begin
         used_in = used_ff - USED_ONE;
      end else begin
         used_in = used_ff;
      end
      if (!do_update) begin
         used_in = used_ff;
      end
   end

   always_comb begin
      status = ST_OK;
      unique case (op_ff)
         OP_ADD:    status = (!any_match && full) ? ST_FULL : ST_OK;
         OP_REMOVE: status = any_match ? ST_OK : ST_NOT_FOUND;
         OP_COUNT:  status = ST_OK;
         OP_GET:    status = any_sel ? ST_OK : ST_RANGE;
         default:   status = ST_OK;
      endcase
   end

   assign occ_full  = ctl.ins ? COUNT_WIDTH'(1) : occ_or;
   assign occ_wide  = 64'(occ_full);
   assign occ       = (occ_wide > 64'hFFFF) ? 16'hFFFF : occ_wide[OCC_W-1:0];
   assign nth_wide  = 64'(key_or);
   assign used_wide = 64'(used_in);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (do_update) begin
         rsp_data_in = {1'b0, used_wide[ENTRIES_W-1:0], nth_wide[IO_KEY_W-1:0], occ, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_FULL)
      else $error("entry count above capacity");

   a_one_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE |-> $onehot0(match_vec))
      else $error("key matched in more than one cell");

   a_one_sel: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("position selects more than one cell");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      do_update && ctl.ins |=> used_ff == $past(used_ff) + USED_ONE)
      else $error("insert did not grow the entry count");

   a_update_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      do_update |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("update did not present a response word");
`endif

endmodule

`default_nettype wire
